@@ rtl/core/pcra_pkg.sv @@
// Shared types and constants for the PCIe capability register access block.
package pcra_pkg;

   // Configuration register indexes on the CSR write port.
   typedef enum logic [2:0] {
      CSR_MSI_BASE           = 3'd0,
      CSR_MSI_OPTIONS        = 3'd1,
      CSR_MSIX_BASE          = 3'd2,
      CSR_MSIX_TABLE_ENTRIES = 3'd3,
      CSR_PM_BASE            = 3'd4,
      CSR_PCIE_BASE          = 3'd5,
      CSR_PASID_BASE         = 3'd6
   } csr_index_type;

   // Capability selected by the address decode.
   typedef enum logic [2:0] {
      CAP_NONE  = 3'd0,
      CAP_MSI   = 3'd1,
      CAP_MSIX  = 3'd2,
      CAP_PM    = 3'd3,
      CAP_PCIE  = 3'd4,
      CAP_PASID = 3'd5
   } cap_type;

   typedef struct packed {
      logic        mode;
      logic [11:0] address;
      logic [2:0]  access_size;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic        handled;
      logic [31:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  msi_base;
      logic [1:0]  msi_options;
      logic [7:0]  msix_base;
      logic [11:0] msix_table_entries;
      logic [7:0]  pm_base;
      logic [7:0]  pcie_base;
      logic [11:0] pasid_base;
   } cfg_type;

   // Offset is relative to the capability base; no range is longer than 60 bytes.
   typedef struct packed {
      cap_type    cap;
      logic [5:0] offset;
   } access_type;

   localparam logic        MODE_WRITE = 1'b1;

   localparam logic [2:0]  SIZE_HALF = 3'd2;
   localparam logic [2:0]  SIZE_WORD = 3'd4;

   localparam logic [12:0] MSI_LEN_MIN  = 13'd12;
   localparam logic [12:0] MSI_LEN_WIDE = 13'd4;
   localparam logic [12:0] MSI_LEN_MASK = 13'd8;
   localparam logic [12:0] MSIX_LEN     = 13'd12;
   localparam logic [12:0] PM_LEN       = 13'd8;
   localparam logic [12:0] PCIE_LEN     = 13'd60;
   localparam logic [12:0] PASID_LEN    = 13'd8;

   localparam logic [5:0]  OFF_CTRL       = 6'd2;
   localparam logic [5:0]  OFF_MSI_ADDR_L = 6'd4;
   localparam logic [5:0]  OFF_MSI_ADDR_H = 6'd8;
   localparam logic [5:0]  OFF_MSI_DATA32 = 6'd8;
   localparam logic [5:0]  OFF_MSI_DATA64 = 6'd12;
   localparam logic [5:0]  OFF_MSI_MASK32 = 6'd12;
   localparam logic [5:0]  OFF_MSI_MASK64 = 6'd16;
   localparam logic [5:0]  OFF_PM_CTRL    = 6'd4;
   localparam logic [5:0]  OFF_PASID_CTRL = 6'd6;

   localparam logic [15:0] PM_CTRL_MASK    = 16'h8103;
   localparam logic [2:0]  PASID_CTRL_MASK = 3'h7;

endpackage

@@ rtl/core/pcra_csr.sv @@
// Configuration registers holding the capability placement and options.
module pcra_csr import pcra_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_write_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MSI_BASE:           cfg_in.msi_base           = csr_write_data[7:0];
            CSR_MSI_OPTIONS:        cfg_in.msi_options        = csr_write_data[1:0];
            CSR_MSIX_BASE:          cfg_in.msix_base          = csr_write_data[7:0];
            CSR_MSIX_TABLE_ENTRIES: cfg_in.msix_table_entries = csr_write_data;
            CSR_PM_BASE:            cfg_in.pm_base            = csr_write_data[7:0];
            CSR_PCIE_BASE:          cfg_in.pcie_base          = csr_write_data[7:0];
            CSR_PASID_BASE:         cfg_in.pasid_base         = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                    <= '0;
         cfg_ff.msi_options        <= 2'd1;
         cfg_ff.msix_table_entries <= 12'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/pcra_cap_decode.sv @@
// Address decode: picks the capability whose byte range holds the address.
module pcra_cap_decode import pcra_pkg::*; (
   input  cfg_type     cfg,
   input  logic [11:0] address,
   output access_type  acc
);

   function automatic logic in_range(input logic [12:0] addr, input logic [12:0] base,
                                     input logic [12:0] len);
      in_range = (base != 13'd0) && (addr >= base) && (addr < base + len);
   endfunction

   logic [12:0] addr_ext;
   logic [12:0] msi_len;
   logic [11:0] base_sel;
   logic [11:0] diff;

   assign addr_ext = {1'b0, address};
   assign msi_len  = MSI_LEN_MIN + (cfg.msi_options[0] ? MSI_LEN_WIDE : 13'd0)
                                 + (cfg.msi_options[1] ? MSI_LEN_MASK : 13'd0);

   // Overlapping ranges resolve by fixed priority, first match wins.
   always_comb begin
      priority if (in_range(addr_ext, {5'd0, cfg.msi_base}, msi_len)) begin
         acc.cap  = CAP_MSI;
         base_sel = {4'd0, cfg.msi_base};
      end else if (in_range(addr_ext, {5'd0, cfg.msix_base}, MSIX_LEN)) begin
         acc.cap  = CAP_MSIX;
         base_sel = {4'd0, cfg.msix_base};
      end else if (in_range(addr_ext, {5'd0, cfg.pm_base}, PM_LEN)) begin
         acc.cap  = CAP_PM;
         base_sel = {4'd0, cfg.pm_base};
      end else if (in_range(addr_ext, {5'd0, cfg.pcie_base}, PCIE_LEN)) begin
         acc.cap  = CAP_PCIE;
         base_sel = {4'd0, cfg.pcie_base};
      end else if (in_range(addr_ext, {1'b0, cfg.pasid_base}, PASID_LEN)) begin
         acc.cap  = CAP_PASID;
         base_sel = cfg.pasid_base;
      end else begin
         acc.cap  = CAP_NONE;
         base_sel = '0;
      end
      diff       = address - base_sel;
      acc.offset = diff[5:0];
   end

endmodule

@@ rtl/core/pcra_cap_regs.sv @@
// Capability register file: read selection and masked register updates.
module pcra_cap_regs import pcra_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  req_type    req,
   input  access_type acc,
   input  logic       commit,
   output rsp_type    rsp
);

   logic [15:0] msi_control_ff, msi_control_in;
   logic [31:0] msi_addr_low_ff, msi_addr_low_in;
   logic [31:0] msi_addr_high_ff, msi_addr_high_in;
   logic [15:0] msi_data_ff, msi_data_in;
   logic [31:0] msi_mask_ff, msi_mask_in;
   logic [1:0]  msix_enable_ff, msix_enable_in;
   logic [15:0] pm_control_ff, pm_control_in;
   logic [2:0]  pasid_control_ff, pasid_control_in;

   logic        wide;
   logic        is_write;
   logic        half;
   logic        word;
   logic [5:0]  data_off;
   logic [5:0]  mask_off;
   logic [11:0] msix_size_m1;
   logic        hit;
   logic [31:0] rdata;

   assign wide         = cfg.msi_options[0];
   assign is_write     = (req.mode == MODE_WRITE);
   assign half         = (req.access_size == SIZE_HALF);
   assign word         = (req.access_size == SIZE_WORD);
   assign data_off     = wide ? OFF_MSI_DATA64 : OFF_MSI_DATA32;
   assign mask_off     = wide ? OFF_MSI_MASK64 : OFF_MSI_MASK32;
   assign msix_size_m1 = cfg.msix_table_entries - 12'd1;

   always_comb begin
      hit              = 1'b0;
      rdata            = '0;
      msi_control_in   = msi_control_ff;
      msi_addr_low_in  = msi_addr_low_ff;
      msi_addr_high_in = msi_addr_high_ff;
      msi_data_in      = msi_data_ff;
      msi_mask_in      = msi_mask_ff;
      msix_enable_in   = msix_enable_ff;
      pm_control_in    = pm_control_ff;
      pasid_control_in = pasid_control_ff;
      if (!is_write) begin
         unique case (acc.cap)
            CAP_MSI: begin
               if (acc.offset == OFF_CTRL && half) begin
                  hit   = 1'b1;
                  rdata = {16'd0, msi_control_ff};
               end else if (acc.offset == OFF_MSI_ADDR_L) begin
                  hit   = 1'b1;
                  rdata = msi_addr_low_ff;
               end else if (wide && acc.offset == OFF_MSI_ADDR_H) begin
                  hit   = 1'b1;
                  rdata = msi_addr_high_ff;
               end else if (acc.offset == data_off) begin
                  hit   = 1'b1;
                  rdata = {16'd0, msi_data_ff};
               end
            end
            CAP_MSIX: begin
               if (acc.offset == OFF_CTRL && half) begin
                  hit   = 1'b1;
                  rdata = {16'd0, msix_enable_ff, 3'd0, msix_size_m1[10:0]};
               end
            end
            CAP_PM: begin
               if (acc.offset == OFF_PM_CTRL && half) begin
                  hit   = 1'b1;
                  rdata = {16'd0, pm_control_ff};
               end
            end
            CAP_PASID: begin
               if (acc.offset == OFF_PASID_CTRL && half) begin
                  hit   = 1'b1;
                  rdata = {29'd0, pasid_control_ff};
               end
            end
            default: ;
         endcase
      end else begin
         // Writes inside the PCIe capability are claimed but change nothing.
         unique case (acc.cap)
            CAP_MSI: begin
               if (acc.offset == OFF_CTRL && half) begin
                  hit            = 1'b1;
                  msi_control_in = req.write_data[15:0];
               end else if (acc.offset == OFF_MSI_ADDR_L && word) begin
                  hit             = 1'b1;
                  msi_addr_low_in = req.write_data;
               end else if (wide && acc.offset == OFF_MSI_ADDR_H && word) begin
                  hit              = 1'b1;
                  msi_addr_high_in = req.write_data;
               end else if (acc.offset == data_off && half) begin
                  hit         = 1'b1;
                  msi_data_in = req.write_data[15:0];
               end else if (acc.offset == mask_off && word) begin
                  hit         = 1'b1;
                  msi_mask_in = req.write_data;
               end
            end
            CAP_MSIX: begin
               if (acc.offset == OFF_CTRL && half) begin
                  hit            = 1'b1;
                  msix_enable_in = req.write_data[15:14];
               end
            end
            CAP_PM: begin
               if (acc.offset == OFF_PM_CTRL && half) begin
                  hit           = 1'b1;
                  pm_control_in = req.write_data[15:0] & PM_CTRL_MASK;
               end
            end
            CAP_PCIE: hit = 1'b1;
            CAP_PASID: begin
               if (acc.offset == OFF_PASID_CTRL && half) begin
                  hit              = 1'b1;
                  pasid_control_in = req.write_data[2:0] & PASID_CTRL_MASK;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msi_control_ff   <= '0;
         msi_addr_low_ff  <= '0;
         msi_addr_high_ff <= '0;
         msi_data_ff      <= '0;
         msi_mask_ff      <= '0;
         msix_enable_ff   <= '0;
         pm_control_ff    <= '0;
         pasid_control_ff <= '0;
      end else if (commit) begin
         msi_control_ff   <= msi_control_in;
         msi_addr_low_ff  <= msi_addr_low_in;
         msi_addr_high_ff <= msi_addr_high_in;
         msi_data_ff      <= msi_data_in;
         msi_mask_ff      <= msi_mask_in;
         msix_enable_ff   <= msix_enable_in;
         pm_control_ff    <= pm_control_in;
         pasid_control_ff <= pasid_control_in;
      end
   end

   assign rsp.handled   = hit;
   assign rsp.read_data = rdata;

endmodule

@@ rtl/core/pcie_capability_register_access.sv @@
// Top level of the PCIe capability register access block.
//
// Config-space accesses enter on the req_ channel (valid/stall) as one
// transaction each: read or write, byte address, access size and write data.
// Every transaction yields exactly one response on the rsp_ channel carrying
// a handled flag and, for claimed reads, the register value.
// The csr_ port places the MSI, MSI-X, PM, PCIe and PASID capabilities and
// sets the MSI layout and MSI-X table size; write it only while idle.
// A transaction is captured in an input register, then decoded and applied
// once the output register is free, and its response is held in that output
// register until the receiver takes it.
// Throughput is one transaction per cycle unless the receiver stalls: the input
// register refills in the same cycle its contents move to the output register.
// When the receiver stalls, the response holds and the input register keeps
// the next transaction; req_stall rises only while both registers are full.
// Reset empties both pipeline registers (their payloads are not cleared),
// clears all capability registers and sets the configuration to its defaults.
module pcie_capability_register_access import pcra_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_write_data
);

   cfg_type    cfg;
   access_type acc;
   rsp_type    rsp_next;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff;

   logic out_free;
   logic advance;
   logic accept;

   pcra_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   pcra_cap_decode u_decode (
      .cfg     (cfg),
      .address (s1_req_ff.address),
      .acc     (acc)
   );

   pcra_cap_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req    (s1_req_ff),
      .acc    (acc),
      .commit (advance),
      .rsp    (rsp_next)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_payload;
      end
      if (advance) begin
         rsp_payload_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ rtl/core/pcra_checker.sv @@
// Port-level checker for the capability register access block, with its bind.
module pcra_checker import pcra_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // A stalled response stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

   // The input side only backs up when a stalled response fills the output.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output backpressure");

   // Unclaimed transactions return zero data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.handled |-> rsp_payload.read_data == 32'd0)
      else $error("unclaimed transaction returned data");

   // No response is pending right after reset.
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind pcie_capability_register_access pcra_checker u_pcra_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

@@ verif/pcie_capability_register_access_tb.sv @@
// Self-checking testbench for the PCIe capability register access block.
module pcie_capability_register_access_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pcra_pkg::*;

   localparam logic ACCESS_READ  = 1'b0;
   localparam logic ACCESS_WRITE = 1'b1;

   localparam int ONE_BYTE   = 1;
   localparam int HALF_BYTES = 2;
   localparam int WORD_BYTES = 4;

   localparam int REG_CONTROL       = 2;
   localparam int REG_MSI_ADDR_LOW  = 4;
   localparam int REG_MSI_ADDR_HIGH = 8;
   localparam int REG_PM_CONTROL    = 4;
   localparam int REG_PASID_CONTROL = 6;

   localparam int MSIX_SPAN  = 12;
   localparam int PM_SPAN    = 8;
   localparam int PCIE_SPAN  = 60;
   localparam int PASID_SPAN = 8;

   localparam logic [15:0] PM_WRITABLE    = 16'h8103;
   localparam logic [10:0] MSIX_SIZE_MASK = 11'h7FF;

   localparam logic [2:0] CSR_UNUSED_INDEX = 3'd7;

   localparam int RESET_CYCLES    = 12;
   localparam int DRAIN_CYCLES    = 4;
   localparam int HOLD_CYCLES     = 60;
   localparam int STUCK_LIMIT     = 2000;
   localparam int RANDOM_PHASES   = 9;
   localparam int ITEMS_PER_PHASE = 180;
   localparam int PRESSURE_ITEMS  = 48;

   localparam cfg_type SETTINGS_RESET = '{msi_base: 8'd0, msi_options: 2'd1, msix_base: 8'd0,
      msix_table_entries: 12'd1, pm_base: 8'd0, pcie_base: 8'd0, pasid_base: 12'd0};
   localparam cfg_type SETTINGS_LAYOUT = '{msi_base: 8'h50, msi_options: 2'd3,
      msix_base: 8'h70, msix_table_entries: 12'd2048, pm_base: 8'h40, pcie_base: 8'h80,
      pasid_base: 12'h100};
   localparam cfg_type SETTINGS_OVERLAP = '{msi_base: 8'hF8, msi_options: 2'd3,
      msix_base: 8'hFC, msix_table_entries: 12'd1, pm_base: 8'hFC, pcie_base: 8'hF0,
      pasid_base: 12'h104};
   localparam cfg_type SETTINGS_HIGH = '{msi_base: 8'hFF, msi_options: 2'd3, msix_base: 8'hFF,
      msix_table_entries: 12'd2048, pm_base: 8'hFF, pcie_base: 8'hFF, pasid_base: 12'hFFF};
   localparam cfg_type SETTINGS_LOW = '{msi_base: 8'd1, msi_options: 2'd0, msix_base: 8'd1,
      msix_table_entries: 12'd1, pm_base: 8'd1, pcie_base: 8'd1, pasid_base: 12'd1};

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [11:0] csr_write_data = '0;

   // Local copy of the configuration and of the capability registers.
   cfg_type     settings = SETTINGS_RESET;
   logic [15:0] msi_control = '0;
   logic [31:0] msi_addr_low = '0;
   logic [31:0] msi_addr_high = '0;
   logic [15:0] msi_data = '0;
   logic [31:0] msi_mask = '0;
   logic [1:0]  msix_enable = '0;
   logic [15:0] pm_control = '0;
   logic [2:0]  pasid_control = '0;

   rsp_type access_outcomes[$];
   rsp_type outcome;

   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int settings_count = 0;
   int input_stall_cycles = 0;

   bit              hold_off_request = 1'b0;
   int              hold_left = 0;
   int              segment_left = 0;
   stall_style_type stall_style = STALL_NONE;

   pcie_capability_register_access u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int msi_span();
      return 12 + (settings.msi_options[0] ? 4 : 0) + (settings.msi_options[1] ? 8 : 0);
   endfunction

   function automatic bit in_window(input int addr, input int base, input int span);
      return base != 0 && addr >= base && addr < base + span;
   endfunction

   // Decodes one transaction against the current layout, updates the capability
   // registers on a claimed write and returns the response the block must give.
   function automatic rsp_type apply_capability_access(input req_type acc);
      rsp_type res;
      cap_type cap;
      int      addr;
      int      base;
      int      off;
      int      size;
      bit      wide;
      int      data_off;
      int      mask_off;
      res = '0;
      addr = acc.address;
      size = acc.access_size;
      wide = settings.msi_options[0];
      data_off = wide ? 12 : 8;
      mask_off = wide ? 16 : 12;
      cap = CAP_NONE;
      base = 0;
      if (in_window(addr, settings.msi_base, msi_span())) begin
         cap = CAP_MSI;
         base = settings.msi_base;
      end else if (in_window(addr, settings.msix_base, MSIX_SPAN)) begin
         cap = CAP_MSIX;
         base = settings.msix_base;
      end else if (in_window(addr, settings.pm_base, PM_SPAN)) begin
         cap = CAP_PM;
         base = settings.pm_base;
      end else if (in_window(addr, settings.pcie_base, PCIE_SPAN)) begin
         cap = CAP_PCIE;
         base = settings.pcie_base;
      end else if (in_window(addr, settings.pasid_base, PASID_SPAN)) begin
         cap = CAP_PASID;
         base = settings.pasid_base;
      end
      off = addr - base;

      if (acc.mode == ACCESS_READ) begin
         case (cap)
            CAP_MSI: begin
               res.handled = 1'b1;
               if (off == REG_CONTROL && size == HALF_BYTES) begin
                  res.read_data = {16'h0, msi_control};
               end else if (off == REG_MSI_ADDR_LOW) begin
                  res.read_data = msi_addr_low;
               end else if (wide && off == REG_MSI_ADDR_HIGH) begin
                  res.read_data = msi_addr_high;
               end else if (off == data_off) begin
                  res.read_data = {16'h0, msi_data};
               end else begin
                  res.handled = 1'b0;
               end
            end
            CAP_MSIX: begin
               if (off == REG_CONTROL && size == HALF_BYTES) begin
                  res.handled = 1'b1;
                  res.read_data = {16'h0, msix_enable, 3'b000,
                     11'(settings.msix_table_entries - 12'd1) & MSIX_SIZE_MASK};
               end
            end
            CAP_PM: begin
               if (off == REG_PM_CONTROL && size == HALF_BYTES) begin
                  res.handled = 1'b1;
                  res.read_data = {16'h0, pm_control};
               end
            end
            CAP_PASID: begin
               if (off == REG_PASID_CONTROL && size == HALF_BYTES) begin
                  res.handled = 1'b1;
                  res.read_data = {29'h0, pasid_control};
               end
            end
            default: begin
            end
         endcase
      end else begin
         case (cap)
            CAP_MSI: begin
               res.handled = 1'b1;
               if (off == REG_CONTROL && size == HALF_BYTES) begin
                  msi_control = acc.write_data[15:0];
               end else if (off == REG_MSI_ADDR_LOW && size == WORD_BYTES) begin
                  msi_addr_low = acc.write_data;
               end else if (wide && off == REG_MSI_ADDR_HIGH && size == WORD_BYTES) begin
                  msi_addr_high = acc.write_data;
               end else if (off == data_off && size == HALF_BYTES) begin
                  msi_data = acc.write_data[15:0];
               end else if (off == mask_off && size == WORD_BYTES) begin
                  msi_mask = acc.write_data;
               end else begin
                  res.handled = 1'b0;
               end
            end
            CAP_MSIX: begin
               if (off == REG_CONTROL && size == HALF_BYTES) begin
                  res.handled = 1'b1;
                  msix_enable = acc.write_data[15:14];
               end
            end
            CAP_PM: begin
               if (off == REG_PM_CONTROL && size == HALF_BYTES) begin
                  res.handled = 1'b1;
                  pm_control = acc.write_data[15:0] & PM_WRITABLE;
               end
            end
            // Writes into the PCIe capability are claimed and dropped.
            CAP_PCIE: res.handled = 1'b1;
            CAP_PASID: begin
               if (off == REG_PASID_CONTROL && size == HALF_BYTES) begin
                  res.handled = 1'b1;
                  pasid_control = acc.write_data[2:0];
               end
            end
            default: begin
            end
         endcase
      end
      return res;
   endfunction

   function automatic cfg_type random_settings(input bit scattered);
      cfg_type cfg;
      cfg.msi_options = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0: cfg.msix_table_entries = 12'd1;
         1: cfg.msix_table_entries = 12'd2048;
         default: cfg.msix_table_entries = 12'($urandom_range(1, 2048));
      endcase
      if (scattered) begin
         cfg.msi_base = 8'($urandom_range(0, 255));
         cfg.msix_base = 8'($urandom_range(0, 255));
         cfg.pm_base = 8'($urandom_range(0, 255));
         cfg.pcie_base = 8'($urandom_range(0, 255));
         cfg.pasid_base = 12'($urandom_range(0, 4095));
      end else begin
         // Mostly disjoint placement with a little jitter; PCIe may still run into PASID.
         cfg.pm_base = 8'(8'h40 + 4 * $urandom_range(0, 1));
         cfg.msi_base = 8'(8'h50 + 4 * $urandom_range(0, 1));
         cfg.msix_base = 8'(8'h70 + 4 * $urandom_range(0, 1));
         cfg.pcie_base = 8'(8'h80 + 4 * $urandom_range(0, 31));
         cfg.pasid_base = 12'(12'h100 + 4 * $urandom_range(0, 958));
         case ($urandom_range(0, 9))
            0: cfg.msi_base = '0;
            1: cfg.msix_base = '0;
            2: cfg.pm_base = '0;
            3: cfg.pcie_base = '0;
            4: cfg.pasid_base = '0;
            default: begin
            end
         endcase
      end
      return cfg;
   endfunction

   // Mostly aims at register offsets of a present capability; the rest is noise.
   function automatic req_type random_access();
      req_type acc;
      int      pick;
      int      base;
      int      span;
      int      off;
      int      reg_offsets[7] = '{0, 2, 4, 6, 8, 12, 16};
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: begin
            base = settings.msi_base;
            span = msi_span();
         end
         3, 4: begin
            base = settings.msix_base;
            span = MSIX_SPAN;
         end
         5, 6: begin
            base = settings.pm_base;
            span = PM_SPAN;
         end
         7: begin
            base = settings.pcie_base;
            span = PCIE_SPAN;
         end
         8: begin
            base = settings.pasid_base;
            span = PASID_SPAN;
         end
         default: begin
            base = 0;
            span = 0;
         end
      endcase
      if (base == 0) begin
         acc.address = 12'($urandom_range(0, 4095));
      end else begin
         if ($urandom_range(0, 3) != 0) begin
            off = reg_offsets[$urandom_range(0, 6)];
         end else begin
            off = $urandom_range(0, span + 3);
         end
         acc.address = 12'(base + off);
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: acc.access_size = 3'(HALF_BYTES);
         4, 5, 6: acc.access_size = 3'(WORD_BYTES);
         7: acc.access_size = 3'(ONE_BYTE);
         default: acc.access_size = 3'($urandom_range(0, 7));
      endcase
      acc.mode = $urandom_range(0, 1) ? ACCESS_WRITE : ACCESS_READ;
      case ($urandom_range(0, 9))
         0: acc.write_data = 32'h0000_0000;
         1: acc.write_data = 32'hFFFF_FFFF;
         default: acc.write_data = $urandom();
      endcase
      return acc;
   endfunction

   // Leaves valid high on return so back-to-back transactions need no second assignment.
   task automatic send_access(input req_type acc);
      req_valid <= 1'b1;
      req_payload <= acc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      access_outcomes.push_back(apply_capability_access(acc));
      sent_count++;
   endtask

   task automatic send_fields(input logic mode, input logic [11:0] address, input int size,
                              input logic [31:0] data);
      req_type acc;
      acc.mode = mode;
      acc.address = address;
      acc.access_size = 3'(size);
      acc.write_data = data;
      send_access(acc);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (access_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [11:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   // Upper data bits beyond each register are junk and must be dropped by the block.
   task automatic apply_settings(input cfg_type cfg);
      csr_write(CSR_MSI_BASE, {4'($urandom_range(0, 15)), cfg.msi_base});
      csr_write(CSR_MSI_OPTIONS, {10'($urandom()), cfg.msi_options});
      csr_write(CSR_MSIX_BASE, {4'($urandom_range(0, 15)), cfg.msix_base});
      csr_write(CSR_MSIX_TABLE_ENTRIES, cfg.msix_table_entries);
      csr_write(CSR_PM_BASE, {4'($urandom_range(0, 15)), cfg.pm_base});
      csr_write(CSR_PCIE_BASE, {4'($urandom_range(0, 15)), cfg.pcie_base});
      csr_write(CSR_PASID_BASE, cfg.pasid_base);
      csr_write(CSR_UNUSED_INDEX, 12'($urandom()));
      csr_write_enable <= 1'b0;
      settings = cfg;
      settings_count++;
   endtask

   // Nothing is placed after reset, so every transaction falls outside all capabilities.
   task automatic test_reset_state();
      send_fields(ACCESS_READ, 12'h000, 0, 32'h0000_0000);
      send_fields(ACCESS_WRITE, 12'hFFF, 7, 32'hFFFF_FFFF);
      wait_drained();
   endtask

   task automatic test_register_rules();
      apply_settings(SETTINGS_LAYOUT);
      send_fields(ACCESS_WRITE, 12'h052, HALF_BYTES, 32'hFFFF_FFFF);
      send_fields(ACCESS_READ, 12'h052, HALF_BYTES, 32'h0);
      send_fields(ACCESS_WRITE, 12'h052, WORD_BYTES, 32'h0);
      send_fields(ACCESS_WRITE, 12'h054, WORD_BYTES, 32'hFFFF_FFFF);
      send_fields(ACCESS_READ, 12'h054, ONE_BYTE, 32'h0);
      send_fields(ACCESS_WRITE, 12'h058, WORD_BYTES, 32'hA5A5_5A5A);
      send_fields(ACCESS_READ, 12'h058, WORD_BYTES, 32'h0);
      send_fields(ACCESS_WRITE, 12'h05C, HALF_BYTES, 32'hFFFF_1234);
      send_fields(ACCESS_READ, 12'h05C, HALF_BYTES, 32'h0);
      // The mask takes writes but is never readable.
      send_fields(ACCESS_WRITE, 12'h060, WORD_BYTES, 32'hFFFF_FFFF);
      send_fields(ACCESS_READ, 12'h060, WORD_BYTES, 32'h0);
      send_fields(ACCESS_WRITE, 12'h072, HALF_BYTES, 32'hFFFF_FFFF);
      send_fields(ACCESS_READ, 12'h072, HALF_BYTES, 32'h0);
      send_fields(ACCESS_WRITE, 12'h044, HALF_BYTES, 32'hFFFF_FFFF);
      send_fields(ACCESS_READ, 12'h044, HALF_BYTES, 32'h0);
      send_fields(ACCESS_WRITE, 12'h080, WORD_BYTES, 32'hFFFF_FFFF);
      send_fields(ACCESS_READ, 12'h080, WORD_BYTES, 32'h0);
      send_fields(ACCESS_WRITE, 12'h106, HALF_BYTES, 32'hFFFF_FFFF);
      send_fields(ACCESS_READ, 12'h106, HALF_BYTES, 32'h0);
      send_fields(ACCESS_READ, 12'h050, WORD_BYTES, 32'h0);
      // An address-low read has no size condition, so an odd size is still claimed.
      send_fields(ACCESS_READ, 12'h054, 7, 32'h0);
      send_fields(ACCESS_READ, 12'hFFF, 0, 32'h0);
      wait_drained();
   endtask

   // MSI spans 0xF8..0x10F and shadows MSI-X, PM, PASID and part of PCIe.
   task automatic test_overlap_priority();
      apply_settings(SETTINGS_OVERLAP);
      send_fields(ACCESS_READ, 12'h104, HALF_BYTES, 32'h0);
      send_fields(ACCESS_WRITE, 12'h0FE, HALF_BYTES, 32'hFFFF_FFFF);
      send_fields(ACCESS_WRITE, 12'h110, WORD_BYTES, 32'h1234_5678);
      send_fields(ACCESS_READ, 12'h0F0, HALF_BYTES, 32'h0);
      wait_drained();
   endtask

   // The receiver holds off long enough for both pipeline stages to fill.
   task automatic test_backpressure();
      apply_settings(random_settings(1'b0));
      hold_off_request = 1'b1;
      for (int n = 0; n < PRESSURE_ITEMS; n++) send_access(random_access());
      wait_drained();
   endtask

   task automatic test_random_traffic();
      cfg_type cfg;
      int      burst_left;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            cfg = SETTINGS_HIGH;
         end else if (phase == 1) begin
            cfg = SETTINGS_LOW;
         end else begin
            cfg = random_settings(phase % 2 == 0);
         end
         apply_settings(cfg);
         burst_left = 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
            end
            burst_left--;
            send_access(random_access());
         end
         wait_drained();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (segment_left == 0) begin
            segment_left = $urandom_range(8, 80);
            stall_style = stall_style_type'($urandom_range(0, 3));
         end
         segment_left--;
         case (stall_style)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (access_outcomes.size() == 0) begin
            $display("%0t: response with no transaction pending: handled %0b, read_data %h",
                     $time, rsp_payload.handled, rsp_payload.read_data);
            error_count++;
         end else begin
            outcome = access_outcomes.pop_front();
            if (rsp_payload.handled !== outcome.handled) begin
               $display("%0t: handled mismatch: expected %0b, actual %0b",
                        $time, outcome.handled, rsp_payload.handled);
               error_count++;
            end
            if (rsp_payload.read_data !== outcome.read_data) begin
               $display("%0t: read_data mismatch: expected %h, actual %h",
                        $time, outcome.read_data, rsp_payload.read_data);
               error_count++;
            end
            checked_count++;
         end
      end
   end

   initial begin : watchdog
      int stuck_cycles;
      stuck_cycles = 0;
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if (req_valid && req_stall) input_stall_cycles++;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
         end
      end
      $display("%0t: timeout, no transaction moved for %0d cycles", $time, STUCK_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_register_rules();
      test_overlap_priority();
      test_backpressure();
      test_random_traffic();
      $display("Checked %0d responses to %0d config accesses under %0d register layouts.",
               checked_count, sent_count, settings_count);
      $display("Request side was held back on %0d cycles, including a %0d-cycle output hold.",
               input_stall_cycles, HOLD_CYCLES);
      if (error_count == 0 && access_outcomes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
